### src/bcrc_pkg.sv
// shared constants for the byte command range classifier
package bcrc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int INDEX_W         = 6;
    localparam int HANDLER_W       = 7;

    localparam logic [1:0] REQ_DECODE    = 2'd0;
    localparam logic [1:0] REQ_LOAD_VAL  = 2'd1;
    localparam logic [1:0] REQ_LOAD_MARK = 2'd2;

    localparam logic       MODE_ASCII  = 1'b0;
    localparam logic       MODE_BINARY = 1'b1;

    localparam logic [7:0] TERM_BYTE  = 8'hff;
    localparam logic [7:0] RANGE_BIT  = 8'h80;
    localparam logic [7:0] LOW_MASK   = 8'h7f;

endpackage

### src/bcrc_ram.sv
// generic single write port ram with registered read
module bcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/byte_command_range_classifier.sv
// byte command range classifier top level: table walker and table stores
//
// Each decode request walks the command table from entry 0, one entry per clock unless a
// stalled result holds the walk, and returns the handler index of the first single entry
// or range that holds the byte, or the default handler at the table end, or an overrun
// flag if the walk runs past TABLE_DEPTH entries. The value and marker stores each have
// one read port, and the walker consumes one entry per read. Load requests (value or
// marker) are written while the block is idle and leave it idle. The block takes no new
// request while a walk is running; a finished result waits in the output register while
// the next request is accepted. The user must write decode_mode through the configuration
// channel only while the block is idle; the block itself does not enforce this.
// Table entries must be written before a walk reads them.
module byte_command_range_classifier #(
    parameter int TABLE_DEPTH = bcrc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [7:0]                    i_data_byte,
    input  logic [bcrc_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [7:0]                    i_entry_value,
    input  logic                          i_entry_bit,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bcrc_pkg::HANDLER_W-1:0] o_handler_index,
    output logic                          o_matched,
    output logic                          o_table_overrun,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (PW + 1 > bcrc_pkg::INDEX_W + 1) ? PW + 1 : bcrc_pkg::INDEX_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [bcrc_pkg::HANDLER_W-1:0] r_handler, n_handler;
    logic [7:0]                     r_lo, n_lo;
    logic [7:0]                     r_byte, n_byte;
    logic                           r_mode;
    logic                           r_out_valid;
    logic [bcrc_pkg::HANDLER_W-1:0] r_out_handler;
    logic                           r_out_matched;
    logic                           r_out_overrun;

    logic                           in_acc;
    logic                           walk_go;
    logic                           emit;
    logic                           emit_hit;
    logic                           emit_over;
    logic [PW:0]                    pos_inc;
    logic [AW-1:0]                  rd_addr;
    logic                           rd_en;
    logic                           idx_ok;
    logic [AW-1:0]                  wr_addr;
    logic                           val_wr;
    logic                           mark_wr;
    logic [7:0]                     rd_val;
    logic                           rd_mark;
    logic                           at_end;
    logic                           at_last;

    assign in_acc  = i_in_valid && o_in_ready;
    assign walk_go = !(r_out_valid && !i_out_ready);
    assign pos_inc = {1'b0, r_pos} + (PW + 1)'(1);
    assign at_end  = (r_pos == PW'(TABLE_DEPTH));
    assign at_last = (r_pos == PW'(TABLE_DEPTH - 1));

    assign idx_ok  = (XW'(i_entry_index) < XW'(TABLE_DEPTH));
    assign wr_addr = AW'(i_entry_index);
    assign val_wr  = in_acc && (i_req_type == bcrc_pkg::REQ_LOAD_VAL) && idx_ok;
    assign mark_wr = in_acc && (i_req_type == bcrc_pkg::REQ_LOAD_MARK) && idx_ok;

    // next entry in walk order; entry 0 while idle
    always_comb begin
        rd_addr = '0;
        if (r_state != ST_IDLE && pos_inc < (PW + 1)'(TABLE_DEPTH)) begin
            rd_addr = pos_inc[AW-1:0];
        end
    end
    assign rd_en = (r_state == ST_IDLE) || walk_go;

    bcrc_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_value_store (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_entry_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_val)
    );

    bcrc_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_marker_store (
        .i_clk     (i_clk),
        .i_wr_en   (mark_wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_entry_bit),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_mark)
    );

    // walk sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_handler = r_handler;
        n_lo      = r_lo;
        n_byte    = r_byte;
        emit      = 1'b0;
        emit_hit  = 1'b0;
        emit_over = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_req_type == bcrc_pkg::REQ_DECODE) begin
                    n_state   = ST_HEAD;
                    n_pos     = '0;
                    n_handler = '0;
                    n_byte    = i_data_byte;
                end
            end
            ST_HEAD: begin
                if (walk_go) begin
                    n_pos = pos_inc[PW-1:0];
                    if (at_end) begin
                        emit      = 1'b1;
                        emit_over = 1'b1;
                    end else if (r_mode == bcrc_pkg::MODE_ASCII) begin
                        if (rd_val == bcrc_pkg::TERM_BYTE) begin
                            emit = 1'b1;
                        end else if ((rd_val & bcrc_pkg::RANGE_BIT) != 8'h00) begin
                            if (at_last) begin
                                emit      = 1'b1;
                                emit_over = 1'b1;
                            end else begin
                                n_lo    = rd_val & bcrc_pkg::LOW_MASK;
                                n_state = ST_TAIL;
                            end
                        end else if (r_byte == rd_val) begin
                            emit     = 1'b1;
                            emit_hit = 1'b1;
                        end else begin
                            n_handler = r_handler + bcrc_pkg::HANDLER_W'(1);
                        end
                    end else begin
                        if (rd_mark) begin
                            if (at_last) begin
                                emit      = 1'b1;
                                emit_over = 1'b1;
                            end else begin
                                n_lo    = rd_val;
                                n_state = ST_TAIL;
                            end
                        end else if (r_byte == rd_val) begin
                            emit     = 1'b1;
                            emit_hit = 1'b1;
                        end else begin
                            n_handler = r_handler + bcrc_pkg::HANDLER_W'(1);
                        end
                    end
                    if (emit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (walk_go) begin
                    n_pos = pos_inc[PW-1:0];
                    if (r_mode == bcrc_pkg::MODE_BINARY && rd_mark) begin
                        emit = 1'b1;
                    end else if (r_byte >= r_lo && r_byte <= rd_val) begin
                        emit     = 1'b1;
                        emit_hit = 1'b1;
                    end else begin
                        n_handler = r_handler + bcrc_pkg::HANDLER_W'(1);
                        n_state   = ST_HEAD;
                    end
                    if (emit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_handler   <= '0;
            r_mode      <= bcrc_pkg::MODE_ASCII;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_handler <= n_handler;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_byte <= n_byte;
        if (emit) begin
            r_out_handler <= r_handler;
            r_out_matched <= emit_hit;
            r_out_overrun <= emit_over;
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_handler_index = r_out_handler;
    assign o_matched       = r_out_matched;
    assign o_table_overrun = r_out_overrun;

`ifndef SYNTHESIS
    a_decode_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_req_type == bcrc_pkg::REQ_DECODE |=> r_state == ST_HEAD)
        else $error("decode request did not start a walk");

    a_hit_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_matched && o_table_overrun))
        else $error("result both matched and overrun");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_pos <= PW'(TABLE_DEPTH))
        else $error("walk position past table end");

    a_tail_after_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TAIL |-> r_pos != '0 && $past(r_state) != ST_IDLE)
        else $error("range tail without a head entry");

    a_stall_holds_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE && !walk_go |=> $stable(r_pos) && $stable(r_handler))
        else $error("walk advanced while result was stalled");
`endif

endmodule

### dv/tb_byte_command_range_classifier.sv
// testbench for the byte command range classifier: directed table, random tables, scoreboard
`timescale 1ns / 100ps

module tb_byte_command_range_classifier;

    localparam int TABLE_DEPTH   = bcrc_pkg::TABLE_DEPTH_DEF;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int ITEM_TARGET   = 950;
    localparam int N_DIRECTED    = 24;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        TS_ASCII_END,
        TS_ASCII_RUN,
        TS_BIN_END,
        TS_BIN_RUN
    } t_table_style;

    typedef struct packed {
        logic [bcrc_pkg::HANDLER_W-1:0] handler;
        logic                           hit;
        logic                           overrun;
    } t_decode_result;

    typedef struct packed {
        logic                         is_mode;
        logic [1:0]                   req;
        logic [7:0]                   rx_byte;
        logic [bcrc_pkg::INDEX_W-1:0] idx;
        logic [7:0]                   val;
        logic                         mark_bit;
        logic                         typed;
        t_decode_result               want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_req_type = bcrc_pkg::REQ_DECODE;
    logic [7:0]                     i_data_byte = 8'h00;
    logic [bcrc_pkg::INDEX_W-1:0]   i_entry_index = '0;
    logic [7:0]                     i_entry_value = 8'h00;
    logic                           i_entry_bit = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [bcrc_pkg::HANDLER_W-1:0] o_handler_index;
    logic                           o_matched;
    logic                           o_table_overrun;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic                           i_cfg_data = 1'b0;

    // shadow of the command table and mode
    logic [7:0]     tbl_val  [TABLE_DEPTH];
    logic           tbl_mark [TABLE_DEPTH];
    bit             val_set  [TABLE_DEPTH];
    bit             mark_set [TABLE_DEPTH];
    logic           cur_mode = bcrc_pkg::MODE_ASCII;

    t_decode_result pending_results [$];
    int             mismatch_count = 0;
    int             items_sent = 0;
    logic           calm = 1'b0;
    int             hold_reqs = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    logic [7:0]     plan_val  [TABLE_DEPTH];
    logic           plan_mark [TABLE_DEPTH];
    int             plan_len = 1;
    t_stim_row      directed_rows [N_DIRECTED];

    byte_command_range_classifier i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_entry_bit     (i_entry_bit),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_handler_index (o_handler_index),
        .o_matched       (o_matched),
        .o_table_overrun (o_table_overrun),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // walk of the shadow table; safe is cleared when an entry never loaded is touched
    function automatic t_decode_result classify_byte(input logic [7:0] rx_byte,
                                                     output bit safe);
        t_decode_result r;
        int pos;
        int handler;
        bit done;
        pos = 0;
        handler = 0;
        done = 1'b0;
        safe = 1'b1;
        r.hit = 1'b0;
        r.overrun = 1'b1;
        while (!done && pos < TABLE_DEPTH) begin
            safe = safe & val_set[pos] & mark_set[pos];
            if (cur_mode == bcrc_pkg::MODE_BINARY) begin
                if (tbl_mark[pos]) begin
                    if (pos + 1 >= TABLE_DEPTH) break;
                    safe = safe & val_set[pos + 1] & mark_set[pos + 1];
                    if (tbl_mark[pos + 1]) begin
                        r.overrun = 1'b0;
                        done = 1'b1;
                    end else if (rx_byte >= tbl_val[pos] && rx_byte <= tbl_val[pos + 1]) begin
                        r.hit = 1'b1;
                        r.overrun = 1'b0;
                        done = 1'b1;
                    end else begin
                        pos += 2;
                    end
                end else if (rx_byte == tbl_val[pos]) begin
                    r.hit = 1'b1;
                    r.overrun = 1'b0;
                    done = 1'b1;
                end else begin
                    pos += 1;
                end
            end else begin
                if (tbl_val[pos] == bcrc_pkg::TERM_BYTE) begin
                    r.overrun = 1'b0;
                    done = 1'b1;
                end else if ((tbl_val[pos] & bcrc_pkg::RANGE_BIT) != 8'h00) begin
                    if (pos + 1 >= TABLE_DEPTH) break;
                    safe = safe & val_set[pos + 1] & mark_set[pos + 1];
                    if (rx_byte >= (tbl_val[pos] & bcrc_pkg::LOW_MASK) &&
                        rx_byte <= tbl_val[pos + 1]) begin
                        r.hit = 1'b1;
                        r.overrun = 1'b0;
                        done = 1'b1;
                    end else begin
                        pos += 2;
                    end
                end else if (rx_byte == tbl_val[pos]) begin
                    r.hit = 1'b1;
                    r.overrun = 1'b0;
                    done = 1'b1;
                end else begin
                    pos += 1;
                end
            end
            if (!done) handler++;
        end
        r.handler = bcrc_pkg::HANDLER_W'(handler);
        return r;
    endfunction

    function automatic t_stim_row req_row(input logic [1:0] req, input logic [7:0] rx_byte,
                                          input int idx, input logic [7:0] val,
                                          input logic mark_bit);
        t_stim_row r;
        r = '0;
        r.req = req;
        r.rx_byte = rx_byte;
        r.idx = bcrc_pkg::INDEX_W'(idx);
        r.val = val;
        r.mark_bit = mark_bit;
        return r;
    endfunction

    function automatic t_stim_row want_row(input logic [7:0] rx_byte, input int handler,
                                           input logic hit, input logic overrun);
        t_stim_row r;
        r = req_row(bcrc_pkg::REQ_DECODE, rx_byte, 0, 8'h00, 1'b0);
        r.typed = 1'b1;
        r.want.handler = bcrc_pkg::HANDLER_W'(handler);
        r.want.hit = hit;
        r.want.overrun = overrun;
        return r;
    endfunction

    function automatic t_stim_row mode_row(input logic mode);
        t_stim_row r;
        r = '0;
        r.is_mode = 1'b1;
        r.mark_bit = mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_req(input logic [1:0] req, input logic [7:0] rx_byte,
                            input logic [bcrc_pkg::INDEX_W-1:0] idx, input logic [7:0] val,
                            input logic mark_bit, input logic typed,
                            input t_decode_result want);
        int gap;
        bit safe;
        t_decode_result predicted;
        gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_data_byte   <= rx_byte;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_entry_bit   <= mark_bit;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (req)
            bcrc_pkg::REQ_DECODE: begin
                predicted = classify_byte(rx_byte, safe);
                pending_results.push_back(typed ? want : predicted);
            end
            bcrc_pkg::REQ_LOAD_VAL: begin
                tbl_val[idx] = val;
                val_set[idx] = 1'b1;
            end
            bcrc_pkg::REQ_LOAD_MARK: begin
                tbl_mark[idx] = mark_bit;
                mark_set[idx] = 1'b1;
            end
            default: ;
        endcase
        if (req != REQ_UNUSED) items_sent++;
    endtask

    task automatic send_decode();
        logic [7:0] base;
        logic [7:0] rx;
        bit safe;
        base = plan_val[$urandom_range(0, plan_len - 1)];
        if (cur_mode == bcrc_pkg::MODE_ASCII && $urandom_range(0, 1) == 1) begin
            base = base & bcrc_pkg::LOW_MASK;
        end
        case ($urandom_range(0, 5))
            0, 1:    rx = base;
            2:       rx = base + 8'd1;
            3:       rx = base - 8'd1;
            4:       rx = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
            default: rx = 8'($urandom);
        endcase
        void'(classify_byte(rx, safe));
        if (safe) begin
            send_req(bcrc_pkg::REQ_DECODE, rx, bcrc_pkg::INDEX_W'($urandom), 8'($urandom),
                     1'($urandom), 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_mode = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // result side: compare and drive ready
    always @(posedge i_clk) begin
        t_decode_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, handler_index", int'(o_handler_index), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_handler_index !== want.handler)
                    report_mismatch("handler_index", int'(o_handler_index),
                                    int'(want.handler));
                if (o_matched !== want.hit)
                    report_mismatch("matched", int'(o_matched), int'(want.hit));
                if (o_table_overrun !== want.overrun)
                    report_mismatch("table_overrun", int'(o_table_overrun),
                                    int'(want.overrun));
            end
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int phase;
        int pos;
        int stop;
        int lo;
        int pick;
        bit all_single;
        bit mixed;
        logic new_mode;
        t_table_style style;

        directed_rows = '{
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 0, 8'h41, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 1, bcrc_pkg::RANGE_BIT | 8'h30, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 2, 8'h39, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 3, bcrc_pkg::TERM_BYTE, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_MARK, 8'h00, 0, 8'h00, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_MARK, 8'h00, 1, 8'h00, 1'b1),
            req_row(bcrc_pkg::REQ_LOAD_MARK, 8'h00, 2, 8'h00, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_MARK, 8'h00, 3, 8'h00, 1'b1),
            want_row(8'h41, 0, 1'b1, 1'b0),
            req_row(bcrc_pkg::REQ_DECODE, 8'h30, 0, 8'h00, 1'b0),
            req_row(bcrc_pkg::REQ_DECODE, 8'h39, 0, 8'h00, 1'b0),
            want_row(8'h00, 2, 1'b0, 1'b0),
            want_row(8'hff, 2, 1'b0, 1'b0),
            req_row(REQ_UNUSED, 8'hff, 63, 8'hff, 1'b1),
            mode_row(bcrc_pkg::MODE_BINARY),
            req_row(bcrc_pkg::REQ_LOAD_MARK, 8'h00, 4, 8'h00, 1'b1),
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 4, 8'h00, 1'b0),
            want_row(8'h41, 0, 1'b1, 1'b0),
            want_row(8'h35, 2, 1'b0, 1'b0),
            req_row(bcrc_pkg::REQ_LOAD_VAL, 8'h00, 0, bcrc_pkg::TERM_BYTE, 1'b0),
            want_row(8'hff, 0, 1'b1, 1'b0),
            req_row(bcrc_pkg::REQ_DECODE, 8'h00, 0, 8'h00, 1'b0),
            mode_row(bcrc_pkg::MODE_ASCII),
            want_row(8'h80, 0, 1'b0, 1'b0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_mode) begin
                wait_idle();
                write_mode(directed_rows[r].mark_bit);
            end else begin
                send_req(directed_rows[r].req, directed_rows[r].rx_byte, directed_rows[r].idx,
                         directed_rows[r].val, directed_rows[r].mark_bit,
                         directed_rows[r].typed, directed_rows[r].want);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            style = (pick < 7) ? TS_ASCII_END : (pick < 14) ? TS_BIN_END :
                    (pick < 17) ? TS_ASCII_RUN : TS_BIN_RUN;
            if (phase == 0) style = TS_ASCII_RUN;
            all_single = (phase == 0) || ($urandom_range(0, 3) == 0);

            // build the next command table
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                plan_val[i]  = 8'($urandom);
                plan_mark[i] = 1'($urandom);
            end
            pos = 0;
            stop = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : $urandom_range(1, 10);
            if (style == TS_ASCII_RUN || style == TS_BIN_RUN) stop = TABLE_DEPTH;
            if (style == TS_ASCII_END || style == TS_ASCII_RUN) begin
                while (pos < stop) begin
                    lo = $urandom_range(0, 8'h7e);
                    if (!all_single && $urandom_range(0, 2) == 0 &&
                        (pos + 1 < stop || style == TS_ASCII_RUN)) begin
                        plan_val[pos] = bcrc_pkg::RANGE_BIT | 8'(lo);
                        if (pos + 1 < TABLE_DEPTH) begin
                            plan_val[pos + 1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                8'(lo + $urandom_range(0, 12));
                        end
                        pos += 2;
                    end else begin
                        plan_val[pos] = 8'($urandom_range(0, 8'h7f));
                        pos += 1;
                    end
                end
                if (style == TS_ASCII_END) begin
                    plan_val[pos] = bcrc_pkg::TERM_BYTE;
                    pos += 1;
                end
            end else begin
                while (pos < stop) begin
                    if (!all_single && $urandom_range(0, 2) == 0 &&
                        (pos + 1 < stop || style == TS_BIN_RUN)) begin
                        plan_mark[pos] = 1'b1;
                        if (pos + 1 < TABLE_DEPTH) begin
                            plan_mark[pos + 1] = 1'b0;
                            plan_val[pos + 1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                8'(plan_val[pos] + $urandom_range(0, 12));
                        end
                        pos += 2;
                    end else begin
                        plan_mark[pos] = 1'b0;
                        pos += 1;
                    end
                end
                if (style == TS_BIN_END) begin
                    plan_mark[pos]     = 1'b1;
                    plan_mark[pos + 1] = 1'b1;
                    pos += 2;
                end
            end
            plan_len = (pos > TABLE_DEPTH) ? TABLE_DEPTH : pos;

            new_mode = (style == TS_BIN_END || style == TS_BIN_RUN) ? bcrc_pkg::MODE_BINARY :
                       bcrc_pkg::MODE_ASCII;
            if ($urandom_range(0, 7) == 0) new_mode = ~new_mode;
            wait_idle();
            calm <= (phase >= 4 && phase <= 7);
            if (new_mode != cur_mode || $urandom_range(0, 3) == 0) write_mode(new_mode);
            mixed = (phase % 5 == 3);

            for (int i = 0; i < plan_len; i++) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_req(bcrc_pkg::REQ_LOAD_VAL, 8'($urandom), bcrc_pkg::INDEX_W'(i),
                             plan_val[i], 1'($urandom), 1'b0, '0);
                    send_req(bcrc_pkg::REQ_LOAD_MARK, 8'($urandom), bcrc_pkg::INDEX_W'(i),
                             8'($urandom), plan_mark[i], 1'b0, '0);
                end else begin
                    send_req(bcrc_pkg::REQ_LOAD_MARK, 8'($urandom), bcrc_pkg::INDEX_W'(i),
                             8'($urandom), plan_mark[i], 1'b0, '0);
                    send_req(bcrc_pkg::REQ_LOAD_VAL, 8'($urandom), bcrc_pkg::INDEX_W'(i),
                             plan_val[i], 1'($urandom), 1'b0, '0);
                end
                if (mixed && $urandom_range(0, 3) == 0) send_decode();
                if ($urandom_range(0, 19) == 0) begin
                    send_req(REQ_UNUSED, 8'($urandom), bcrc_pkg::INDEX_W'($urandom),
                             8'($urandom), 1'($urandom), 1'b0, '0);
                end
            end

            // in phase 2 the receiver holds off while decode requests keep coming
            if (phase == 2) hold_reqs <= hold_reqs + 1;
            repeat ($urandom_range(10, 40)) send_decode();
            phase++;
        end

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
